[rtl/core/fejs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fejs_pkg
// Shared types, geometry and codes of the flash erase job sequencer.
// ----------------------------------------------------------------------------
package fejs_pkg;

    // flash geometry (sector and subsector sizes are powers of two)
    localparam int FLASH_BYTES     = 16777216;
    localparam int SECTOR_BYTES    = 65536;
    localparam int SUBSECTOR_BYTES = 4096;
    localparam int MAX_RETRIES     = 3;

    // field widths
    localparam int ADDR_W   = 24;
    localparam int JADDR_W  = 25;
    localparam int MS_W     = 16;
    localparam int WIDE_W   = 27;
    localparam int CFG_IDX_W = 3;

    // stream payload widths
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 72;

    typedef logic [WIDE_W-1:0] t_wide;

    // geometry in datapath width
    localparam t_wide FLASH_W   = WIDE_W'(FLASH_BYTES);
    localparam t_wide SECTOR_W  = WIDE_W'(SECTOR_BYTES);
    localparam t_wide SUBSEC_W  = WIDE_W'(SUBSECTOR_BYTES);
    localparam logic [1:0] RETRY_LIMIT = 2'(MAX_RETRIES);

    // command kinds
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    // poll codes of the pending erase
    localparam logic [1:0] POLL_OK   = 2'd0;
    localparam logic [1:0] POLL_BUSY = 2'd1;

    // job status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_PROTECTED = 2'd1;
    localparam logic [1:0] ST_FAILED    = 2'd2;
    localparam logic [1:0] ST_REFUSED   = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PROT_EN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROT_START = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PROT_END   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_MS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SUBSEC_MS  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_POLL_AVAIL = 3'd5;

    // configuration reset values
    localparam logic [MS_W-1:0] SECTOR_MS_RST = 16'd400;
    localparam logic [MS_W-1:0] SUBSEC_MS_RST = 16'd50;

endpackage : fejs_pkg
`default_nettype wire

[rtl/core/flash_erase_job_sequencer_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// flash_erase_job_sequencer_top
// Erase job sequencer for a NOR flash with sectors and subsectors.
// ----------------------------------------------------------------------------
// A start transaction (tuser 0) loads a job, aligned down and rounded up to
// whole subsectors. Each step transaction (tuser 1) brings the poll of the
// pending erase and the blank and refuse flags; the block answers with one
// result transaction per input: the erase to issue, the wait time and the job
// status, with tlast marking the step that ends the job. One transaction is
// taken every clock cycle while the result stream does not stall; the input
// register takes the transaction and a single pass of the step logic feeds
// the result register once the result register is free. Configuration
// writes must be made only while no transaction is in flight.
module flash_erase_job_sequencer_top (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    // configuration write port
    input  wire                           i_cfg_we,
    input  wire [fejs_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  wire [fejs_pkg::JADDR_W-1:0]   i_cfg_wdata,
    // input stream
    input  wire                           i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // tdata: start_addr[23:0], job_length[48:24], erase_result[50:49],
    //        region_blank[51], begin_refused[52], zero fill
    input  wire [fejs_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    // tuser: cmd[0]
    input  wire                           i_s_axis_tuser,
    // result stream
    output logic                          o_m_axis_tvalid,
    input  wire                           i_m_axis_tready,
    // tdata: issue_erase[0], erase_addr[24:1], erase_is_sector[25],
    //        wait_ms[41:26], status[43:42], next_addr[68:44],
    //        job_active[69], zero fill
    output logic [fejs_pkg::M_TDATA_W-1:0] o_m_axis_tdata,
    // tlast: finished
    output logic                          o_m_axis_tlast
);
    import fejs_pkg::*;

    // configuration registers
    logic               r_prot_en;
    logic [ADDR_W-1:0]  r_prot_start;
    logic [JADDR_W-1:0] r_prot_end;
    logic [MS_W-1:0]    r_sector_ms;
    logic [MS_W-1:0]    r_subsec_ms;
    logic               r_poll_avail;

    // input stage
    logic               r_in_valid;
    logic               r_in_cmd;
    logic [ADDR_W-1:0]  r_in_start;
    logic [JADDR_W-1:0] r_in_len;
    logic [1:0]         r_in_poll;
    logic               r_in_blank;
    logic               r_in_refused;

    // job state
    logic               r_job_running, n_job_running;
    logic               r_erase_pending, n_erase_pending;
    logic               r_unit_sector, n_unit_sector;
    logic [1:0]         r_retry_count, n_retry_count;
    logic [JADDR_W-1:0] r_cursor_addr, n_cursor_addr;
    logic [JADDR_W-1:0] r_job_end, n_job_end;
    logic [MS_W-1:0]    r_expected_time, n_expected_time;

    // result register
    logic               r_out_valid;
    logic [M_TDATA_W-1:0] r_out_data;
    logic               r_out_last;

    // step results
    logic               res_issue;
    logic [ADDR_W-1:0]  res_eaddr;
    logic               res_esec;
    logic [MS_W-1:0]    res_wait;
    logic               res_fin;
    logic [1:0]         res_status;

    // datapath temporaries
    logic               go_on;
    t_wide              st_a, st_len, st_end;
    t_wide              cur_w, unit_w, unit_top;
    logic               pick_sector;
    logic [MS_W-1:0]    sel_ms;
    logic [MS_W+2:0]    ms_x7;
    logic [MS_W-1:0]    wait_busy, wait_issue;

    // handshake
    logic out_free, in_accept, in_fire;
    assign out_free  = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_in_valid || out_free;
    assign in_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign in_fire   = r_in_valid && out_free;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prot_en    <= 1'b0;
            r_prot_start <= '0;
            r_prot_end   <= '0;
            r_sector_ms  <= SECTOR_MS_RST;
            r_subsec_ms  <= SUBSEC_MS_RST;
            r_poll_avail <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_PROT_EN:    r_prot_en    <= i_cfg_wdata[0];
                CFG_PROT_START: r_prot_start <= i_cfg_wdata[ADDR_W-1:0];
                CFG_PROT_END:   r_prot_end   <= i_cfg_wdata;
                CFG_SECTOR_MS:  r_sector_ms  <= i_cfg_wdata[MS_W-1:0];
                CFG_SUBSEC_MS:  r_subsec_ms  <= i_cfg_wdata[MS_W-1:0];
                CFG_POLL_AVAIL: r_poll_avail <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (out_free) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_cmd     <= i_s_axis_tuser;
            r_in_start   <= i_s_axis_tdata[23:0];
            r_in_len     <= i_s_axis_tdata[48:24];
            r_in_poll    <= i_s_axis_tdata[50:49];
            r_in_blank   <= i_s_axis_tdata[51];
            r_in_refused <= i_s_axis_tdata[52];
        end
    end

    // wait times: an eighth while busy, seven eighths after issue, at least 1
    assign wait_busy  = (r_expected_time[MS_W-1:3] == '0) ? MS_W'(1)
                                                           : MS_W'(r_expected_time >> 3);
    assign sel_ms     = pick_sector ? r_sector_ms : r_subsec_ms;
    assign ms_x7      = ({sel_ms, 3'b000}) - {3'b000, sel_ms};
    assign wait_issue = (ms_x7[MS_W+2:3] == '0) ? MS_W'(1) : ms_x7[MS_W+2:3];

    // start job: align, round and saturate
    assign st_a   = WIDE_W'(r_in_start) & ~(SUBSEC_W - 1'b1);
    assign st_len = (WIDE_W'(r_in_len) + SUBSEC_W - 1'b1) & ~(SUBSEC_W - 1'b1);
    always_comb begin
        st_end = st_a + st_len;
        if (st_end > FLASH_W) begin
            st_end = FLASH_W;
        end
    end

    // one pass of the step logic
    always_comb begin
        n_job_running   = r_job_running;
        n_erase_pending = r_erase_pending;
        n_unit_sector   = r_unit_sector;
        n_retry_count   = r_retry_count;
        n_cursor_addr   = r_cursor_addr;
        n_job_end       = r_job_end;
        n_expected_time = r_expected_time;
        res_issue  = 1'b0;
        res_eaddr  = '0;
        res_esec   = 1'b0;
        res_wait   = '0;
        res_fin    = 1'b0;
        res_status = ST_OK;
        go_on       = 1'b1;
        cur_w       = '0;
        pick_sector = 1'b0;
        unit_w      = SUBSEC_W;
        unit_top    = '0;

        if (r_in_cmd == CMD_START) begin
            n_cursor_addr   = st_a[JADDR_W-1:0];
            n_job_end       = st_end[JADDR_W-1:0];
            n_retry_count   = '0;
            n_erase_pending = 1'b0;
            n_unit_sector   = 1'b0;
            n_expected_time = '0;
            if (st_end <= st_a) begin
                n_job_running = 1'b0;
                res_fin       = 1'b1;
            end else begin
                n_job_running = 1'b1;
            end
        end else if (r_job_running) begin
            // collect the poll of the pending erase
            if (r_erase_pending) begin
                if (r_in_poll == POLL_BUSY) begin
                    res_wait = wait_busy;
                    go_on    = 1'b0;
                end else begin
                    n_erase_pending = 1'b0;
                    if (r_in_poll == POLL_OK) begin
                        n_cursor_addr = JADDR_W'(WIDE_W'(r_cursor_addr)
                                        + (r_unit_sector ? SECTOR_W : SUBSEC_W));
                        n_retry_count = '0;
                    end else if (r_retry_count < RETRY_LIMIT) begin
                        n_retry_count = r_retry_count + 2'd1;
                    end else begin
                        res_status = ST_FAILED;
                        res_fin    = 1'b1;
                        go_on      = 1'b0;
                    end
                end
            end

            // end of range
            if (go_on && (n_cursor_addr >= r_job_end)) begin
                res_fin = 1'b1;
                go_on   = 1'b0;
            end

            // pick and handle the next unit
            if (go_on) begin
                cur_w       = WIDE_W'(n_cursor_addr);
                pick_sector = ((cur_w & (SECTOR_W - 1'b1)) == '0)
                              && ((cur_w + SECTOR_W) <= WIDE_W'(r_job_end));
                unit_w      = pick_sector ? SECTOR_W : SUBSEC_W;
                unit_top    = cur_w + unit_w;
                n_unit_sector = pick_sector;
                priority if (r_prot_en && (cur_w < WIDE_W'(r_prot_end))
                             && (unit_top > WIDE_W'(r_prot_start))) begin
                    res_status = ST_PROTECTED;
                    res_fin    = 1'b1;
                end else if (r_in_blank) begin
                    n_cursor_addr = unit_top[JADDR_W-1:0];
                end else if (r_in_refused) begin
                    res_status = ST_REFUSED;
                    res_fin    = 1'b1;
                end else begin
                    res_issue = 1'b1;
                    res_eaddr = cur_w[ADDR_W-1:0];
                    res_esec  = pick_sector;
                    if (r_poll_avail) begin
                        n_erase_pending = 1'b1;
                        n_expected_time = sel_ms;
                        res_wait        = wait_issue;
                    end else begin
                        n_cursor_addr = unit_top[JADDR_W-1:0];
                        n_retry_count = '0;
                    end
                end
            end

            if (res_fin) begin
                n_job_running   = 1'b0;
                n_erase_pending = 1'b0;
            end
        end
    end

    // job state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_running   <= 1'b0;
            r_erase_pending <= 1'b0;
            r_unit_sector   <= 1'b0;
            r_retry_count   <= '0;
            r_cursor_addr   <= '0;
            r_job_end       <= '0;
            r_expected_time <= '0;
        end else if (in_fire) begin
            r_job_running   <= n_job_running;
            r_erase_pending <= n_erase_pending;
            r_unit_sector   <= n_unit_sector;
            r_retry_count   <= n_retry_count;
            r_cursor_addr   <= n_cursor_addr;
            r_job_end       <= n_job_end;
            r_expected_time <= n_expected_time;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out_data <= {2'b00, n_job_running, n_cursor_addr, res_status,
                           res_wait, res_esec, res_eaddr, res_issue};
            r_out_last <= res_fin;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;

endmodule : flash_erase_job_sequencer_top
`default_nettype wire

[test/flash_erase_job_sequencer_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flash_erase_job_sequencer_top_tb
// Self-checking bench for the erase job sequencer. Start and step transactions
// go in over the input stream, each result transaction is compared field by
// field with a cycle-free model of the job logic kept in the bench, across
// several register settings, random idling on both streams and a long
// receiver hold-off that backs up the block.
// ----------------------------------------------------------------------------
module flash_erase_job_sequencer_top_tb;
    import fejs_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int SETTLE_CYCLES = 6;
    localparam int HOLD_CYCLES = 300;
    localparam int MAX_REPORTS = 200;

    // poll codes the package leaves unnamed
    localparam logic [1:0] POLL_FAIL    = 2'd2;
    localparam logic [1:0] POLL_UNKNOWN = 2'd3;

    // geometry in 32-bit arithmetic
    localparam logic [31:0] SEC_SIZE   = SECTOR_BYTES;
    localparam logic [31:0] SUB_SIZE   = SUBSECTOR_BYTES;
    localparam logic [31:0] FLASH_SIZE = FLASH_BYTES;
    localparam logic [31:0] SEC_MASK   = SECTOR_BYTES - 1;
    localparam logic [31:0] SUB_MASK   = SUBSECTOR_BYTES - 1;
    localparam logic [31:0] WAIT_NUM   = 7;
    localparam logic [31:0] WAIT_SHIFT = 3;

    typedef struct packed {
        logic               cmd;
        logic [ADDR_W-1:0]  start_addr;
        logic [JADDR_W-1:0] job_length;
        logic [1:0]         erase_result;
        logic               region_blank;
        logic               begin_refused;
    } t_erase_cmd;

    typedef struct packed {
        logic               issue;
        logic [ADDR_W-1:0]  addr;
        logic               is_sector;
        logic [MS_W-1:0]    wait_ms;
        logic               finished;
        logic [1:0]         status;
        logic [JADDR_W-1:0] next_addr;
        logic               active;
    } t_erase_report;

    // block ports
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_addr = '0;
    logic [JADDR_W-1:0]    i_cfg_wdata = '0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [S_TDATA_W-1:0]  i_s_axis_tdata = '0;
    logic                  i_s_axis_tuser = 1'b0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  o_m_axis_tdata;
    logic                  o_m_axis_tlast;

    // mirror of the registers
    logic               prot_en = 1'b0;
    logic [ADDR_W-1:0]  prot_lo = '0;
    logic [JADDR_W-1:0] prot_hi = '0;
    logic [MS_W-1:0]    sector_ms = SECTOR_MS_RST;
    logic [MS_W-1:0]    subsec_ms = SUBSEC_MS_RST;
    logic               poll_avail = 1'b1;

    // mirror of the job state
    logic               job_on = 1'b0;
    logic               pend = 1'b0;
    logic               unit_sec = 1'b0;
    logic [1:0]         retries = '0;
    logic [JADDR_W-1:0] cursor = '0;
    logic [JADDR_W-1:0] job_end = '0;
    logic [MS_W-1:0]    unit_ms = '0;

    t_erase_report due_reports[$];

    int  errors = 0;
    int  reports = 0;
    int  cycle_count = 0;
    int  items_sent = 0;
    int  jobs_started = 0;
    int  erases_issued = 0;
    int  settings_used = 0;
    int  status_seen[4] = '{0, 0, 0, 0};
    bit  tx_idle_on = 1'b1;
    bit  rx_idle_on = 1'b1;
    int  hold_reqs = 0;
    int  hold_taken = 0;
    int  hold_left = 0;
    int  stall_left = 0;

    flash_erase_job_sequencer_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // register write mirror
    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [JADDR_W-1:0] v);
        case (idx)
            CFG_PROT_EN:    prot_en    = v[0];
            CFG_PROT_START: prot_lo    = v[ADDR_W-1:0];
            CFG_PROT_END:   prot_hi    = v;
            CFG_SECTOR_MS:  sector_ms  = v[MS_W-1:0];
            CFG_SUBSEC_MS:  subsec_ms  = v[MS_W-1:0];
            CFG_POLL_AVAIL: poll_avail = v[0];
            default: ;
        endcase
    endfunction

    // next result of the job logic for one accepted transaction
    function automatic t_erase_report sequencer_step(input t_erase_cmd c);
        t_erase_report r;
        logic [31:0] a, len, e, u, w;
        logic go_on;
        r = '0;
        if (c.cmd == CMD_START) begin
            a = {8'd0, c.start_addr} & ~SUB_MASK;
            len = ({7'd0, c.job_length} + SUB_MASK) & ~SUB_MASK;
            e = a + len;
            if (e > FLASH_SIZE)
                e = FLASH_SIZE;
            cursor = a[JADDR_W-1:0];
            job_end = e[JADDR_W-1:0];
            retries = '0;
            pend = 1'b0;
            unit_sec = 1'b0;
            unit_ms = '0;
            job_on = (e > a);
            r.finished = (e <= a);
        end else if (job_on) begin
            go_on = 1'b1;
            // collect the poll of the erase in flight
            if (pend) begin
                if (c.erase_result == POLL_BUSY) begin
                    w = {16'd0, unit_ms} >> WAIT_SHIFT;
                    r.wait_ms = (w == 0) ? 16'd1 : w[MS_W-1:0];
                    go_on = 1'b0;
                end else begin
                    pend = 1'b0;
                    if (c.erase_result == POLL_OK) begin
                        u = unit_sec ? SEC_SIZE : SUB_SIZE;
                        cursor = cursor + u[JADDR_W-1:0];
                        retries = '0;
                    end else if (retries < RETRY_LIMIT) begin
                        retries = retries + 2'd1;
                    end else begin
                        r.status = ST_FAILED;
                        r.finished = 1'b1;
                        go_on = 1'b0;
                    end
                end
            end
            if (go_on && cursor >= job_end) begin
                r.finished = 1'b1;
                go_on = 1'b0;
            end
            // pick and handle the next unit
            if (go_on) begin
                a = {7'd0, cursor};
                unit_sec = ((a & SEC_MASK) == 0) && (a + SEC_SIZE <= {7'd0, job_end});
                u = unit_sec ? SEC_SIZE : SUB_SIZE;
                if (prot_en && a < {7'd0, prot_hi} && a + u > {8'd0, prot_lo}) begin
                    r.status = ST_PROTECTED;
                    r.finished = 1'b1;
                end else if (c.region_blank) begin
                    e = a + u;
                    cursor = e[JADDR_W-1:0];
                end else if (c.begin_refused) begin
                    r.status = ST_REFUSED;
                    r.finished = 1'b1;
                end else begin
                    r.issue = 1'b1;
                    r.addr = a[ADDR_W-1:0];
                    r.is_sector = unit_sec;
                    if (poll_avail) begin
                        pend = 1'b1;
                        unit_ms = unit_sec ? sector_ms : subsec_ms;
                        w = ({16'd0, unit_ms} * WAIT_NUM) >> WAIT_SHIFT;
                        r.wait_ms = (w == 0) ? 16'd1 : w[MS_W-1:0];
                    end else begin
                        e = a + u;
                        cursor = e[JADDR_W-1:0];
                        retries = '0;
                    end
                end
            end
            if (r.finished) begin
                job_on = 1'b0;
                pend = 1'b0;
            end
        end
        r.next_addr = cursor;
        r.active = job_on;
        return r;
    endfunction

    // random content, all fields
    function automatic t_erase_cmd any_cmd();
        t_erase_cmd c;
        c.cmd = 1'($urandom_range(0, 1));
        c.start_addr = ADDR_W'($urandom);
        c.job_length = JADDR_W'($urandom_range(0, FLASH_BYTES));
        c.erase_result = 2'($urandom_range(0, 3));
        c.region_blank = 1'($urandom_range(0, 1));
        c.begin_refused = 1'($urandom_range(0, 1));
        return c;
    endfunction

    function automatic t_erase_cmd start_cmd(input logic [ADDR_W-1:0] addr,
                                             input logic [JADDR_W-1:0] len);
        t_erase_cmd c;
        c = any_cmd();
        c.cmd = CMD_START;
        c.start_addr = addr;
        c.job_length = len;
        return c;
    endfunction

    function automatic t_erase_cmd step_cmd(input logic [1:0] er, input logic blank,
                                            input logic refused);
        t_erase_cmd c;
        c = any_cmd();
        c.cmd = CMD_STEP;
        c.erase_result = er;
        c.region_blank = blank;
        c.begin_refused = refused;
        return c;
    endfunction

    // offer one transaction and wait until it is taken
    task automatic send_item(input t_erase_cmd c);
        t_erase_report r;
        if (tx_idle_on && $urandom_range(0, 99) < 20) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser <= c.cmd;
        i_s_axis_tdata <= {3'd0, c.begin_refused, c.region_blank, c.erase_result,
                           c.job_length, c.start_addr};
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
        r = sequencer_step(c);
        due_reports.push_back(r);
        items_sent++;
        if (c.cmd == CMD_START)
            jobs_started++;
        if (r.issue)
            erases_issued++;
        if (r.finished)
            status_seen[r.status]++;
    endtask

    // stop offering and let every result come back
    task automatic wait_idle();
        i_s_axis_tvalid <= 1'b0;
        while (due_reports.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [JADDR_W-1:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        apply_reg(idx, v);
    endtask

    // full register set, only with the block idle
    task automatic load_config(input logic en, input logic [ADDR_W-1:0] lo,
                               input logic [JADDR_W-1:0] hi, input logic [MS_W-1:0] sms,
                               input logic [MS_W-1:0] ssms, input logic poll);
        wait_idle();
        put_reg(CFG_PROT_EN, {24'd0, en});
        put_reg(CFG_PROT_START, {1'b0, lo});
        put_reg(CFG_PROT_END, hi);
        put_reg(CFG_SECTOR_MS, {9'd0, sms});
        put_reg(CFG_SUBSEC_MS, {9'd0, ssms});
        put_reg(CFG_POLL_AVAIL, {24'd0, poll});
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [MS_W-1:0] pick_ms();
        case ($urandom_range(0, 9))
            0, 1, 2: return MS_W'($urandom_range(1, 16));
            3:       return 16'hFFFF;
            default: return MS_W'($urandom_range(1, 65535));
        endcase
    endfunction

    task automatic random_config();
        logic [ADDR_W-1:0] lo;
        logic [31:0] hi;
        lo = ADDR_W'($urandom);
        if ($urandom_range(0, 9) == 0)
            hi = $urandom_range(0, FLASH_BYTES);
        else
            hi = {8'd0, lo} + $urandom_range(0, 32'h80000);
        if (hi > FLASH_SIZE)
            hi = FLASH_SIZE;
        load_config(1'($urandom_range(0, 1)), lo, hi[JADDR_W-1:0], pick_ms(), pick_ms(),
                    $urandom_range(0, 3) != 0);
    endtask

    // start of a plausible job, often near the protected window or the top
    function automatic t_erase_cmd job_start();
        t_erase_cmd c;
        c = start_cmd(ADDR_W'($urandom), JADDR_W'($urandom_range(1, 32'h60000)));
        case ($urandom_range(0, 3))
            0: c.start_addr = ADDR_W'($urandom & ~SEC_MASK);
            1: c.start_addr = ADDR_W'(prot_lo - $urandom_range(0, 32'h20000));
            2: c.start_addr = ADDR_W'(24'hFFFFFF - $urandom_range(0, 32'h40000));
            default: ;
        endcase
        case ($urandom_range(0, 9))
            0: c.job_length = JADDR_W'($urandom_range(0, SUBSECTOR_BYTES));
            1: c.job_length = JADDR_W'($urandom_range(0, FLASH_BYTES));
            default: ;
        endcase
        return c;
    endfunction

    // step with a poll result shaped by whether an erase is in flight
    function automatic t_erase_cmd job_step();
        int pick;
        logic [1:0] er;
        pick = $urandom_range(0, 99);
        if (!pend)
            er = 2'($urandom_range(0, 3));
        else if (pick < 65)
            er = POLL_OK;
        else if (pick < 80)
            er = POLL_BUSY;
        else if (pick < 94)
            er = POLL_FAIL;
        else
            er = POLL_UNKNOWN;
        return step_cmd(er, $urandom_range(0, 99) < 15, $urandom_range(0, 99) < 4);
    endfunction

    // jobs with random content, some stray transactions in between
    task automatic run_jobs(input int n_items);
        int stop_at, cap, steps;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 99) < 8) begin
                send_item(any_cmd());
            end else begin
                send_item(job_start());
                cap = $urandom_range(4, 40);
                steps = 0;
                while (job_on && steps < cap && items_sent < stop_at) begin
                    send_item(job_step());
                    steps++;
                end
                if ($urandom_range(0, 9) == 0)
                    send_item(job_step());
            end
        end
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_no_job_and_empty();
        send_item(step_cmd(POLL_OK, 1'b0, 1'b0));
        send_item(start_cmd(24'h000000, 25'd0));
        send_item(step_cmd(POLL_FAIL, 1'b0, 1'b0));
    endtask

    task automatic test_retries();
        send_item(start_cmd(24'h000123, 25'd1));
        send_item(step_cmd(POLL_OK, 1'b0, 1'b0));
        send_item(step_cmd(POLL_BUSY, 1'b0, 1'b0));
        send_item(step_cmd(POLL_FAIL, 1'b0, 1'b0));
        send_item(step_cmd(POLL_UNKNOWN, 1'b0, 1'b0));
        send_item(step_cmd(POLL_FAIL, 1'b0, 1'b0));
        send_item(step_cmd(POLL_FAIL, 1'b0, 1'b0));
    endtask

    task automatic test_top_of_flash();
        send_item(start_cmd(24'hFFFFFF, 25'h1000000));
        send_item(step_cmd(POLL_OK, 1'b1, 1'b0));
        send_item(step_cmd(POLL_OK, 1'b0, 1'b0));
    endtask

    task automatic test_unit_choice();
        send_item(start_cmd(24'h010000, 25'h020000));
        send_item(step_cmd(POLL_OK, 1'b0, 1'b1));
        send_item(start_cmd(24'h020000, 25'h010001));
        send_item(step_cmd(POLL_OK, 1'b0, 1'b0));
        send_item(step_cmd(POLL_OK, 1'b0, 1'b0));
        // restart while the subsector erase is still in flight
        send_item(start_cmd(24'h000000, 25'h001000));
        send_item(step_cmd(POLL_FAIL, 1'b0, 1'b0));
        send_item(step_cmd(POLL_OK, 1'b0, 1'b0));
    endtask

    task automatic test_protection_and_timing();
        load_config(1'b1, 24'h005000, 25'h006000, 16'd1, 16'hFFFF, 1'b1);
        send_item(start_cmd(24'h004000, 25'h003000));
        send_item(step_cmd(POLL_OK, 1'b0, 1'b0));
        send_item(step_cmd(POLL_OK, 1'b0, 1'b0));
        load_config(1'b0, 24'h000000, 25'h1000000, 16'd1, 16'd7, 1'b1);
        send_item(start_cmd(24'h000000, 25'h010000));
        send_item(step_cmd(POLL_OK, 1'b0, 1'b0));
        send_item(step_cmd(POLL_BUSY, 1'b0, 1'b0));
        load_config(1'b1, 24'h000000, 25'h1000000, 16'hFFFF, 16'd1, 1'b1);
        send_item(start_cmd(24'h7FF000, 25'h000800));
        send_item(step_cmd(POLL_OK, 1'b0, 1'b0));
    endtask

    task automatic test_immediate_completion();
        load_config(1'b0, 24'hFFFFFF, 25'h1000000, SECTOR_MS_RST, SUBSEC_MS_RST, 1'b0);
        send_item(start_cmd(24'h0F0000, 25'h011000));
        send_item(step_cmd(POLL_BUSY, 1'b0, 1'b0));
        send_item(step_cmd(POLL_BUSY, 1'b0, 1'b0));
        send_item(step_cmd(POLL_BUSY, 1'b0, 1'b0));
    endtask

    task automatic test_random_settings();
        for (int ph = 0; ph < 5; ph++) begin
            random_config();
            rx_idle_on = (ph != 2);
            run_jobs(110);
        end
        rx_idle_on = 1'b1;
    endtask

    // receiver holds off while the sender keeps offering
    task automatic test_backpressure();
        random_config();
        hold_reqs <= hold_reqs + 1;
        tx_idle_on = 1'b0;
        run_jobs(60);
        tx_idle_on = 1'b1;
        wait_idle();
    endtask

    task automatic test_steady_tail();
        random_config();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        run_jobs(120);
        wait_idle();
    endtask

    // --------------------------------------------------------------- processes

    // result side ready, random stalls and the long hold-off
    always @(posedge i_clk) begin
        if (hold_reqs != hold_taken) begin
            hold_taken = hold_reqs;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_m_axis_tready <= 1'b0;
        end else if (rx_idle_on && $urandom_range(0, 99) < 12) begin
            stall_left = $urandom_range(0, 9);
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            errors++;
            if (reports < MAX_REPORTS)
                $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h",
                         $time, name, want, got);
            reports++;
        end
    endtask

    // compare each result transaction with the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_erase_report want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (due_reports.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none actual tdata 0x%0h",
                         $time, o_m_axis_tdata);
            end else begin
                want = due_reports.pop_front();
                check_field("issue_erase", 32'(want.issue), 32'(o_m_axis_tdata[0]));
                check_field("erase_addr", 32'(want.addr), 32'(o_m_axis_tdata[24:1]));
                check_field("erase_is_sector", 32'(want.is_sector),
                            32'(o_m_axis_tdata[25]));
                check_field("wait_ms", 32'(want.wait_ms), 32'(o_m_axis_tdata[41:26]));
                check_field("finished", 32'(want.finished), 32'(o_m_axis_tlast));
                check_field("status", 32'(want.status), 32'(o_m_axis_tdata[43:42]));
                check_field("next_addr", 32'(want.next_addr),
                            32'(o_m_axis_tdata[68:44]));
                check_field("job_active", 32'(want.active), 32'(o_m_axis_tdata[69]));
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, due_reports.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // test sequence
    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_no_job_and_empty();
        test_retries();
        test_top_of_flash();
        test_unit_choice();
        test_protection_and_timing();
        test_immediate_completion();
        test_random_settings();
        test_backpressure();
        test_steady_tail();
        $display("covered %0d transactions in %0d jobs over %0d register settings, %0d erases",
                 items_sent, jobs_started, settings_used, erases_issued);
        $display("job ends: %0d ok, %0d protected, %0d failed, %0d refused; %0d mismatches",
                 status_seen[ST_OK], status_seen[ST_PROTECTED], status_seen[ST_FAILED],
                 status_seen[ST_REFUSED], errors);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
